/* rtl/core/eatrm_pkg.sv */
package eatrm_pkg;

  // Angle resolution (counts per turn is 2^ANGLE_BITS) and output fraction bits.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 15;

  // Internal fixed point: unsigned Q1.31, with 1.0 as 2^31.
  localparam int          QB       = 31;
  localparam logic [31:0] ONE_Q    = 32'h8000_0000;
  localparam logic [31:0] HALFPI_Q = 32'hC90F_DAA2;

  // Reciprocal shift for the constant dividers of the series.
  localparam int RECIP_SH = 40;

  // Series lengths and pipeline depths.
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int SC_LAT    = 25;
  localparam int TOP_LAT   = SC_LAT + 3;

  // Fields carried beside the series lanes.
  typedef struct packed {
    logic [1:0]  quad;
    logic        fold;
    logic [31:0] tr;
    logic [31:0] t2;
  } eatrm_sb_t;

  // Divisors of the sine series, innermost term first.
  function automatic int sin_div(input int i);
    int k;
    case (i)
      0: k = 156;
      1: k = 110;
      2: k = 72;
      3: k = 42;
      4: k = 20;
      default: k = 6;
    endcase
    return k;
  endfunction

  // Divisors of the cosine series, innermost term first.
  function automatic int cos_div(input int i);
    int k;
    case (i)
      0: k = 182;
      1: k = 132;
      2: k = 90;
      3: k = 56;
      4: k = 30;
      5: k = 12;
      default: k = 2;
    endcase
    return k;
  endfunction

  // Rounded Q1.31 product; both operands are at most 1.0.
  function automatic logic [31:0] umul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = 64'(a) * 64'(b) + (64'(1) << (QB - 1));
    return pr[62:31];
  endfunction

  // Signed Q1.31 product, rounded half away from zero.
  function automatic logic signed [32:0] smul(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic        neg;
    logic [32:0] ma;
    logic [32:0] mb;
    logic [31:0] m;
    neg = a[32] ^ b[32];
    ma  = a[32] ? 33'(-a) : 33'(a);
    mb  = b[32] ? 33'(-b) : 33'(b);
    m   = umul32(ma[31:0], mb[31:0]);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Sign extension of a product to the width of a sum.
  function automatic logic signed [33:0] sx34(input logic signed [32:0] a);
    return $signed({a[32], a});
  endfunction

  // Round to FRAC_BITS fraction bits and saturate to the 16-bit field.
  function automatic logic [15:0] to_out(input logic signed [33:0] v);
    localparam int SH = QB - FRAC_BITS;
    localparam logic signed [35:0] HI  = (36'sd1 <<< FRAC_BITS) - 36'sd1;
    localparam logic signed [35:0] LO  = -(36'sd1 <<< FRAC_BITS);
    localparam logic signed [35:0] H16 = 36'sd32767;
    localparam logic signed [35:0] L16 = -36'sd32768;
    logic        neg;
    logic [33:0] m;
    logic [35:0] mr;
    logic signed [35:0] r;
    neg = v[33];
    m   = neg ? 34'(-v) : 34'(v);
    mr  = (36'(m) + (36'd1 << (SH - 1))) >> SH;
    r   = neg ? -$signed(mr) : $signed(mr);
    if (r > HI) r = HI;
    if (r < LO) r = LO;
    if (r > H16) r = H16;
    if (r < L16) r = L16;
    return r[15:0];
  endfunction

endpackage

/* rtl/core/euler_angles_to_rotation_matrix.sv */
// Channel  | Ports                            | Payload
// input    | in_tvalid, in_tready, in_tdata   | phi_one, phi_mid, phi_two (16 bits each)
// output   | out_tvalid, out_tready, out_tdata| m00 .. m22 (16-bit Q1.15 each)
//
// One item enters per cycle unless the pipeline is held, as described below.
// The depth is set by the seven-step cosine series, three stages per step.
// rst_n (synchronous, active low) clears only the valid bits.
// When out_tready is low with a result waiting, the whole pipeline holds
// and in_tready drops; bubbles inside the pipeline are not squeezed out.
module euler_angles_to_rotation_matrix import eatrm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // phi_one[15:0], phi_mid[31:16], phi_two[47:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  logic en;
  logic [TOP_LAT-1:0] vld_r;

  // Pipeline advances unless a finished result is being held.
  assign en        = out_tready | ~vld_r[TOP_LAT-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOP_LAT-2:0], in_tvalid};
    end
  end

  // Sine and cosine of the three angles.
  logic signed [32:0] s1, c1, sm, cm, s2, c2;

  eatrm_sincos u_sc_one (.clk(clk), .en(en), .angle(in_tdata[15:0]),  .sin_q(s1), .cos_q(c1));
  eatrm_sincos u_sc_mid (.clk(clk), .en(en), .angle(in_tdata[31:16]), .sin_q(sm), .cos_q(cm));
  eatrm_sincos u_sc_two (.clk(clk), .en(en), .angle(in_tdata[47:32]), .sin_q(s2), .cos_q(c2));

  // Pairwise products.
  logic signed [32:0] c1c2_r, s1s2_r, s1c2_r, c1s2_r, s2sm_r, c2sm_r, s1sm_r, c1sm_r, cm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1c2_r <= smul(c1, c2);
      s1s2_r <= smul(s1, s2);
      s1c2_r <= smul(s1, c2);
      c1s2_r <= smul(c1, s2);
      s2sm_r <= smul(s2, sm);
      c2sm_r <= smul(c2, sm);
      s1sm_r <= smul(s1, sm);
      c1sm_r <= smul(c1, sm);
      cm_r   <= cm;
    end
  end

  // Triple products with the tilt cosine; the rest is carried along.
  logic signed [32:0] t0_r, t1_r, t3_r, t4_r;
  logic signed [32:0] p_c1c2_r, p_s1s2_r, p_s1c2_r, p_c1s2_r;
  logic signed [32:0] p_s2sm_r, p_c2sm_r, p_s1sm_r, p_c1sm_r, p_cm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r     <= smul(s1s2_r, cm_r);
      t1_r     <= smul(c1s2_r, cm_r);
      t3_r     <= smul(s1c2_r, cm_r);
      t4_r     <= smul(c1c2_r, cm_r);
      p_c1c2_r <= c1c2_r;
      p_s1s2_r <= s1s2_r;
      p_s1c2_r <= s1c2_r;
      p_c1s2_r <= c1s2_r;
      p_s2sm_r <= s2sm_r;
      p_c2sm_r <= c2sm_r;
      p_s1sm_r <= s1sm_r;
      p_c1sm_r <= c1sm_r;
      p_cm_r   <= cm_r;
    end
  end

  // Sums, rounding and saturation into the output register.
  logic [143:0] out_nxt;
  logic [143:0] out_r;

  always_comb begin
    out_nxt[15:0]    = to_out(sx34(p_c1c2_r) - sx34(t0_r));
    out_nxt[31:16]   = to_out(sx34(p_s1c2_r) + sx34(t1_r));
    out_nxt[47:32]   = to_out(sx34(p_s2sm_r));
    out_nxt[63:48]   = to_out(-sx34(p_c1s2_r) - sx34(t3_r));
    out_nxt[79:64]   = to_out(-sx34(p_s1s2_r) + sx34(t4_r));
    out_nxt[95:80]   = to_out(sx34(p_c2sm_r));
    out_nxt[111:96]  = to_out(sx34(p_s1sm_r));
    out_nxt[127:112] = to_out(-sx34(p_c1sm_r));
    out_nxt[143:128] = to_out(sx34(p_cm_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = vld_r[TOP_LAT-1];

endmodule

/* rtl/core/eatrm_sincos.sv */
module eatrm_sincos import eatrm_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         angle,
  output logic signed [32:0]  sin_q,
  output logic signed [32:0]  cos_q
);

  localparam int RB = ANGLE_BITS - 2;
  localparam logic [RB-1:0] QUARTER_M1 = {RB{1'b1}};
  localparam logic [RB-1:0] HALF       = RB'(1) << (RB - 1);

  // Fold stage: quadrant, fold flag and folded offset.
  logic [ANGLE_BITS-1:0] a;
  logic [RB-1:0]         r;
  logic [1:0]            f_quad_r;
  logic                  f_fold_r;
  logic [RB-1:0]         f_t_r;

  assign a = ANGLE_BITS'(angle);
  assign r = a[RB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      f_quad_r <= a[ANGLE_BITS-1:ANGLE_BITS-2];
      f_fold_r <= (r > HALF);
      f_t_r    <= (r > HALF) ? RB'(QUARTER_M1 - r + RB'(1)) : r;
    end
  end

  // Scale the offset to radians in Q1.31.
  logic [RB+31:0] tr_prod;
  logic [1:0]     s_quad_r;
  logic           s_fold_r;
  logic [31:0]    s_tr_r;

  assign tr_prod = (RB+32)'(f_t_r) * (RB+32)'(HALFPI_Q) + (RB+32)'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      s_quad_r <= f_quad_r;
      s_fold_r <= f_fold_r;
      s_tr_r   <= tr_prod[RB+31:RB];
    end
  end

  // Side fields travel with the series lanes, one entry per stage.
  eatrm_sb_t sb_r [0:3*COS_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].quad <= s_quad_r;
      sb_r[0].fold <= s_fold_r;
      sb_r[0].tr   <= s_tr_r;
      sb_r[0].t2   <= umul32(s_tr_r, s_tr_r);
    end
  end

  // Each series step takes three stages: product, reciprocal multiply, correction.
  logic [31:0] sx_r [COS_STEPS];
  logic [31:0] sy_r [COS_STEPS];
  logic [31:0] sq_r [COS_STEPS];
  logic [31:0] sp_r [COS_STEPS];
  logic [31:0] cx_r [COS_STEPS];
  logic [31:0] cy_r [COS_STEPS];
  logic [31:0] cq_r [COS_STEPS];
  logic [31:0] cp_r [COS_STEPS];

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_step
    localparam int          CK = cos_div(i);
    localparam int          SK = sin_div(i);
    localparam logic [40:0] CM = (41'd1 << RECIP_SH) / CK;
    localparam logic [40:0] SM = (41'd1 << RECIP_SH) / SK;

    logic [31:0] cp_in;
    logic [31:0] sp_in;
    logic [72:0] c_rm;
    logic [72:0] s_rm;
    logic [31:0] c_yv;
    logic [31:0] s_yv;
    logic [39:0] c_rem;
    logic [39:0] s_rem;
    logic [31:0] c_qv;
    logic [31:0] s_qv;

    assign cp_in = (i == 0) ? ONE_Q : cp_r[(i == 0) ? 0 : i - 1];
    assign sp_in = (i == 0) ? ONE_Q : sp_r[(i == 0) ? 0 : i - 1];

    assign c_yv = cx_r[i] + 32'(CK / 2);
    assign s_yv = sx_r[i] + 32'(SK / 2);
    assign c_rm = 73'(c_yv) * 73'(CM);
    assign s_rm = 73'(s_yv) * 73'(SM);

    assign c_rem = 40'(cy_r[i]) - 40'(cq_r[i]) * 40'(CK);
    assign s_rem = 40'(sy_r[i]) - 40'(sq_r[i]) * 40'(SK);
    assign c_qv  = (c_rem >= 40'(CK)) ? cq_r[i] + 32'd1 : cq_r[i];
    assign s_qv  = (s_rem >= 40'(SK)) ? sq_r[i] + 32'd1 : sq_r[i];

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[3*i+1] <= sb_r[3*i];
        sb_r[3*i+2] <= sb_r[3*i+1];
        sb_r[3*i+3] <= sb_r[3*i+2];

        // Cosine lane.
        cx_r[i] <= umul32(sb_r[3*i].t2, cp_in);
        cy_r[i] <= c_yv;
        cq_r[i] <= c_rm[71:40];
        cp_r[i] <= (c_qv > ONE_Q) ? 32'd0 : ONE_Q - c_qv;

        // Sine lane; its last slot multiplies the series by the angle.
        if (i < SIN_STEPS) begin
          sx_r[i] <= umul32(sb_r[3*i].t2, sp_in);
          sy_r[i] <= s_yv;
          sq_r[i] <= s_rm[71:40];
          sp_r[i] <= (s_qv > ONE_Q) ? 32'd0 : ONE_Q - s_qv;
        end else begin
          sx_r[i] <= umul32(sb_r[3*i].tr, sp_in);
          sy_r[i] <= sx_r[i];
          sq_r[i] <= sx_r[i];
          sp_r[i] <= sy_r[i];
        end
      end
    end
  end

  // Undo the fold and apply the quadrant signs.
  logic signed [32:0] sv;
  logic signed [32:0] cv;
  logic signed [32:0] s0;
  logic signed [32:0] c0;
  logic signed [32:0] s_nxt;
  logic signed [32:0] c_nxt;
  logic signed [32:0] s_r;
  logic signed [32:0] c_r;

  assign sv = $signed({1'b0, sp_r[COS_STEPS-1]});
  assign cv = $signed({1'b0, cp_r[COS_STEPS-1]});
  assign s0 = sb_r[3*COS_STEPS].fold ? cv : sv;
  assign c0 = sb_r[3*COS_STEPS].fold ? sv : cv;

  always_comb begin
    case (sb_r[3*COS_STEPS].quad)
      2'd0:    begin s_nxt = s0;  c_nxt = c0;  end
      2'd1:    begin s_nxt = c0;  c_nxt = -s0; end
      2'd2:    begin s_nxt = -s0; c_nxt = -c0; end
      default: begin s_nxt = -c0; c_nxt = s0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  assign sin_q = s_r;
  assign cos_q = c_r;

endmodule
